[hw/rtl/banked_interrupt_controller_macros.svh]
// assertion macros for the banked interrupt controller checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef BANKED_INTERRUPT_CONTROLLER_MACROS_SVH
`define BANKED_INTERRUPT_CONTROLLER_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define BIC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define BIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// what must hold in the cycle after a reset edge
`define BIC_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bic_pkg.sv]
// shared types, register offsets, command and trigger codes of the interrupt controller
// no dependencies
`timescale 1ns / 1ps

package bic_pkg;

    // default geometry
    localparam int BIC_NUM_BANKS        = 3;
    localparam int BIC_SOURCES_PER_BANK = 32;

    // field widths
    localparam int BIC_SRC_W  = 7;
    localparam int BIC_DATA_W = 32;
    localparam int BIC_TYPE_W = 3;

    // commands, carried in tuser
    localparam logic [1:0] BIC_CMD_SAMPLE = 2'd0;
    localparam logic [1:0] BIC_CMD_READ   = 2'd1;
    localparam logic [1:0] BIC_CMD_WRITE  = 2'd2;

    // first bank with the relocated soft set / soft clear registers
    localparam logic [1:0] BIC_HI_BANK_FIRST = 2'd2;

    // register offsets within a bank
    localparam logic [5:0] BIC_OFF_MASK    = 6'h00;
    localparam logic [5:0] BIC_OFF_RAW     = 6'h04;
    localparam logic [5:0] BIC_OFF_CLR     = 6'h08;
    localparam logic [5:0] BIC_OFF_MSTAT   = 6'h0c;
    localparam logic [5:0] BIC_OFF_TYPE0   = 6'h10;
    localparam logic [5:0] BIC_OFF_TYPE1   = 6'h14;
    localparam logic [5:0] BIC_OFF_TYPE2   = 6'h18;
    localparam logic [5:0] BIC_OFF_TYPE3   = 6'h1c;
    localparam logic [5:0] BIC_OFF_SEL     = 6'h28;
    localparam logic [5:0] BIC_OFF_SSET_LO = 6'h30;
    localparam logic [5:0] BIC_OFF_SCLR_LO = 6'h34;
    localparam logic [5:0] BIC_OFF_SSET_HI = 6'h24;
    localparam logic [5:0] BIC_OFF_SCLR_HI = 6'h28;

    // trigger types
    localparam logic [2:0] BIC_TRIG_LEVEL_HIGH = 3'h0;
    localparam logic [2:0] BIC_TRIG_LEVEL_LOW  = 3'h1;
    localparam logic [2:0] BIC_TRIG_RISE       = 3'h4;
    localparam logic [2:0] BIC_TRIG_FALL       = 3'h5;
    localparam logic [2:0] BIC_TRIG_BOTH       = 3'h6;

    // result of the pending source search
    typedef struct packed {
        logic                 found;
        logic [BIC_SRC_W-1:0] src;
    } t_next;

    // does one source latch pending on this sample
    function automatic logic trig_hit(input logic [2:0] kind, input logic lvl,
                                      input logic prv);
        logic hit;
        case (kind)
            BIC_TRIG_LEVEL_HIGH: hit = lvl;
            BIC_TRIG_LEVEL_LOW:  hit = !lvl;
            BIC_TRIG_RISE:       hit = lvl & !prv;
            BIC_TRIG_FALL:       hit = prv & !lvl;
            BIC_TRIG_BOTH:       hit = lvl ^ prv;
            default:             hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

[hw/rtl/bic_prio_enc.sv]
// lowest-numbered active source search over all banks
// depends on bic_pkg
`timescale 1ns / 1ps

module bic_prio_enc
    import bic_pkg::*;
#(
    parameter int NUM_BANKS        = BIC_NUM_BANKS,
    parameter int SOURCES_PER_BANK = BIC_SOURCES_PER_BANK
) (
    input  logic [NUM_BANKS*SOURCES_PER_BANK-1:0] i_active,
    output t_next                                 o_next
);

    localparam int PosW = $clog2(SOURCES_PER_BANK);

    logic [NUM_BANKS-1:0] bank_any;
    logic [PosW-1:0]      bank_pos [NUM_BANKS];

    // lowest set bit inside each bank
    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            bank_any[b] = 1'b0;
            bank_pos[b] = '0;
            for (int i = SOURCES_PER_BANK - 1; i >= 0; i--) begin
                if (i_active[b*SOURCES_PER_BANK + i]) begin
                    bank_any[b] = 1'b1;
                    bank_pos[b] = PosW'(i);
                end
            end
        end
    end

    // lowest bank with anything active
    always_comb begin
        o_next = '0;
        for (int b = NUM_BANKS - 1; b >= 0; b--) begin
            if (bank_any[b]) begin
                o_next.found = 1'b1;
                o_next.src   = BIC_SRC_W'(b*SOURCES_PER_BANK) + BIC_SRC_W'(bank_pos[b]);
            end
        end
    end

endmodule

[hw/rtl/banked_interrupt_controller.sv]
// top level of the banked interrupt controller: register file, sampling and result stage
// depends on bic_pkg and bic_prio_enc
`timescale 1ns / 1ps

// Banked interrupt controller. Each transaction on the slave stream either samples one
// bank's source lines (tuser = 0), reads a bank register (1) or writes one (2); every
// transaction yields exactly one result on the master stream carrying the read data,
// a bad-access flag and the lowest pending unmasked source after the transaction took
// effect. One transaction is accepted per clock while s_axis_tready is high; the bank
// registers and the search stage update at the accepting edge, and the priority search
// over the updated pending bits is captured in the output register as that stage advances.
// While a result waits in the output register a further transaction is still taken;
// only when both the search stage and the output register are full does s_axis_tready
// drop. Reset clears all masks, pending bits, previous levels, selects and trigger types.
module banked_interrupt_controller
    import bic_pkg::*;
#(
    parameter int NUM_BANKS        = BIC_NUM_BANKS,
    parameter int SOURCES_PER_BANK = BIC_SOURCES_PER_BANK
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // bank[1:0], reg_offset[7:2], write_data[39:8],
                                       // line_levels[71:40]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // read_data[31:0], irq_request[32],
                                       // next_source[39:33], next_valid[40],
                                       // bad_access[41], zero[47:42]
);

    localparam int BankIdxW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int TypeRowW = SOURCES_PER_BANK * BIC_TYPE_W;
    localparam int TotalSrc = NUM_BANKS * SOURCES_PER_BANK;

    // bank state
    logic [SOURCES_PER_BANK-1:0] r_mask [NUM_BANKS];
    logic [SOURCES_PER_BANK-1:0] r_hw   [NUM_BANKS];
    logic [SOURCES_PER_BANK-1:0] r_soft [NUM_BANKS];
    logic [SOURCES_PER_BANK-1:0] r_prev [NUM_BANKS];
    logic [SOURCES_PER_BANK-1:0] r_sel  [NUM_BANKS];
    logic [TypeRowW-1:0]         r_type [NUM_BANKS];
    logic [SOURCES_PER_BANK-1:0] n_mask [NUM_BANKS];
    logic [SOURCES_PER_BANK-1:0] n_hw   [NUM_BANKS];
    logic [SOURCES_PER_BANK-1:0] n_soft [NUM_BANKS];
    logic [SOURCES_PER_BANK-1:0] n_prev [NUM_BANKS];
    logic [SOURCES_PER_BANK-1:0] n_sel  [NUM_BANKS];
    logic [TypeRowW-1:0]         n_type [NUM_BANKS];

    // search stage and output register
    logic        r_a_valid, n_a_valid;
    logic [31:0] r_a_rd;
    logic        r_a_bad;
    logic        r_out_valid, n_out_valid;
    logic [47:0] r_out_data;

    // unpacked transaction
    logic                        in_acc;
    logic [1:0]                  cmd;
    logic [1:0]                  bank;
    logic [5:0]                  off;
    logic [31:0]                 wd;
    logic [31:0]                 lv;
    logic [2:0]                  bank_ext;
    logic [BankIdxW-1:0]         idx;
    logic                        bank_ok;
    logic                        hi;
    logic [SOURCES_PER_BANK-1:0] wd_m;
    logic [SOURCES_PER_BANK-1:0] lv_m;
    logic [31:0]                 wd_m32;
    logic [1:0]                  word_sel;

    // selected bank view
    logic [SOURCES_PER_BANK-1:0] cur_mask, cur_hw, cur_soft, cur_prev, cur_sel;
    logic [TypeRowW-1:0]         cur_type;
    logic [31:0]                 type_rd;
    logic [TypeRowW-1:0]         type_wr;
    logic [SOURCES_PER_BANK-1:0] hit;

    // decode
    logic        known;
    logic [31:0] rd;
    logic        we_mask, we_clr, we_type, we_sel, we_sset, we_sclr;
    logic        is_bus, do_write, do_sample;
    logic        bad;
    logic [31:0] rd_out;

    logic [TotalSrc-1:0] active;
    t_next               next_res;
    logic                out_adv, a_adv;

    // handshake
    assign out_adv       = !r_out_valid || m_axis_tready;
    assign a_adv         = r_a_valid && out_adv;
    assign s_axis_tready = !r_a_valid || out_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // field split
    assign cmd      = s_axis_tuser;
    assign bank     = s_axis_tdata[1:0];
    assign off      = s_axis_tdata[7:2];
    assign wd       = s_axis_tdata[39:8];
    assign lv       = s_axis_tdata[71:40];
    assign bank_ext = {1'b0, bank};
    assign idx      = bank_ext[BankIdxW-1:0];
    assign bank_ok  = {2'b00, bank} < 4'(NUM_BANKS);
    assign hi       = bank >= BIC_HI_BANK_FIRST;
    assign wd_m     = wd[SOURCES_PER_BANK-1:0];
    assign lv_m     = lv[SOURCES_PER_BANK-1:0];
    assign wd_m32   = 32'(wd_m);
    assign word_sel = off[3:2];

    assign cur_mask = r_mask[idx];
    assign cur_hw   = r_hw[idx];
    assign cur_soft = r_soft[idx];
    assign cur_prev = r_prev[idx];
    assign cur_sel  = r_sel[idx];
    assign cur_type = r_type[idx];

    // trigger-type word read: eight nibbles from the selected word
    always_comb begin
        type_rd = '0;
        for (int w = 0; w < 4; w++) begin
            for (int k = 0; k < 8; k++) begin
                if (word_sel == 2'(w) && (w*8 + k) < SOURCES_PER_BANK) begin
                    type_rd[4*k +: BIC_TYPE_W] = cur_type[(w*8 + k)*BIC_TYPE_W +: BIC_TYPE_W];
                end
            end
        end
    end

    // trigger-type word write: replace the eight sources of the selected word
    always_comb begin
        type_wr = cur_type;
        for (int s = 0; s < SOURCES_PER_BANK; s++) begin
            if (word_sel == 2'(s >> 3)) begin
                type_wr[s*BIC_TYPE_W +: BIC_TYPE_W] = wd_m32[4*(s & 7) +: BIC_TYPE_W];
            end
        end
    end

    // per-source trigger evaluation
    always_comb begin
        for (int i = 0; i < SOURCES_PER_BANK; i++) begin
            hit[i] = trig_hit(cur_type[i*BIC_TYPE_W +: BIC_TYPE_W], lv_m[i], cur_prev[i]);
        end
    end

    // register decode
    always_comb begin
        rd      = '0;
        known   = 1'b1;
        we_mask = 1'b0;
        we_clr  = 1'b0;
        we_type = 1'b0;
        we_sel  = 1'b0;
        we_sset = 1'b0;
        we_sclr = 1'b0;
        if (off[1:0] != 2'b00) begin
            known = 1'b0;
        end else if (off == (hi ? BIC_OFF_SSET_HI : BIC_OFF_SSET_LO)) begin
            rd      = 32'(cur_soft);
            we_sset = 1'b1;
        end else if (off == (hi ? BIC_OFF_SCLR_HI : BIC_OFF_SCLR_LO)) begin
            we_sclr = 1'b1;
        end else begin
            case (off)
                BIC_OFF_MASK: begin
                    rd      = 32'(cur_mask);
                    we_mask = 1'b1;
                end
                BIC_OFF_RAW: begin
                    rd = 32'(cur_hw | cur_soft);
                end
                BIC_OFF_CLR: begin
                    we_clr = 1'b1;
                end
                BIC_OFF_MSTAT: begin
                    rd = 32'((cur_hw | cur_soft) & cur_mask);
                end
                BIC_OFF_TYPE0, BIC_OFF_TYPE1, BIC_OFF_TYPE2, BIC_OFF_TYPE3: begin
                    rd      = type_rd;
                    we_type = 1'b1;
                end
                BIC_OFF_SEL: begin
                    // upper banks map soft clear here, so select is unreachable
                    if (hi) begin
                        known = 1'b0;
                    end else begin
                        rd     = 32'(cur_sel);
                        we_sel = 1'b1;
                    end
                end
                default: begin
                    known = 1'b0;
                end
            endcase
        end
    end

    assign is_bus    = (cmd == BIC_CMD_READ) || (cmd == BIC_CMD_WRITE);
    assign bad       = is_bus && (!bank_ok || !known);
    assign rd_out    = (cmd == BIC_CMD_READ && bank_ok && known) ? rd : 32'd0;
    assign do_write  = in_acc && (cmd == BIC_CMD_WRITE) && bank_ok && known;
    assign do_sample = in_acc && (cmd == BIC_CMD_SAMPLE) && bank_ok;

    // next bank state
    always_comb begin
        n_mask = r_mask;
        n_hw   = r_hw;
        n_soft = r_soft;
        n_prev = r_prev;
        n_sel  = r_sel;
        n_type = r_type;
        if (do_sample) begin
            n_hw[idx]   = cur_hw | hit;
            n_prev[idx] = lv_m;
        end
        if (do_write) begin
            if (we_mask) begin
                n_mask[idx] = wd_m;
            end
            if (we_clr) begin
                n_hw[idx] = cur_hw & ~wd_m;
            end
            if (we_type) begin
                n_type[idx] = type_wr;
            end
            if (we_sel) begin
                n_sel[idx] = wd_m;
            end
            if (we_sset) begin
                n_soft[idx] = cur_soft | wd_m;
            end
            if (we_sclr) begin
                n_soft[idx] = cur_soft & ~wd_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_mask[b] <= '0;
                r_hw[b]   <= '0;
                r_soft[b] <= '0;
                r_prev[b] <= '0;
                r_sel[b]  <= '0;
                r_type[b] <= '0;
            end
        end else begin
            r_mask <= n_mask;
            r_hw   <= n_hw;
            r_soft <= n_soft;
            r_prev <= n_prev;
            r_sel  <= n_sel;
            r_type <= n_type;
        end
    end

    // active sources from the updated state
    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            active[b*SOURCES_PER_BANK +: SOURCES_PER_BANK] = (r_hw[b] | r_soft[b]) & r_mask[b];
        end
    end

    bic_prio_enc #(
        .NUM_BANKS        (NUM_BANKS),
        .SOURCES_PER_BANK (SOURCES_PER_BANK)
    ) u_prio_enc (
        .i_active (active),
        .o_next   (next_res)
    );

    // stage valids
    always_comb begin
        n_a_valid = r_a_valid;
        if (in_acc) begin
            n_a_valid = 1'b1;
        end else if (a_adv) begin
            n_a_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (a_adv) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid   <= n_a_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload of the search stage and the output register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_rd  <= rd_out;
            r_a_bad <= bad;
        end
        if (a_adv) begin
            r_out_data <= {6'b0, r_a_bad, next_res.found, next_res.src, next_res.found, r_a_rd};
        end
    end

endmodule

[hw/rtl/bic_checker.sv]
// port-level checks of the banked interrupt controller's result stream, bound to the top
// depends on banked_interrupt_controller_macros.svh
`timescale 1ns / 1ps
`include "banked_interrupt_controller_macros.svh"

module bic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // a stalled result transaction holds
    `BIC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // request line and valid flag of the search agree
    `BIC_ASSERT_IMPL(a_irq_matches_valid, m_axis_tvalid, m_axis_tdata[32] == m_axis_tdata[40], "irq_request differs from next_valid")

    // no pending source reports source zero
    `BIC_ASSERT_IMPL(a_src_zero_when_none, m_axis_tvalid && !m_axis_tdata[40], m_axis_tdata[39:33] == 7'd0, "next_source nonzero with nothing pending")

    // reset empties the output register
    `BIC_ASSERT_RESET(a_reset_empties, !m_axis_tvalid, "result valid right after reset")

endmodule

bind banked_interrupt_controller bic_checker u_bic_checker (.*);

[bench/bic_result_checker.sv]
// result checker for the banked interrupt controller: watches both streams, predicts, compares
// depends on bic_pkg
`timescale 1ns / 1ps

module bic_result_checker
    import bic_pkg::*;
#(
    parameter int NUM_BANKS = BIC_NUM_BANKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side of the block
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,   // bank[1:0], reg_offset[7:2], write_data[39:8],
                                     // line_levels[71:40]
    input  logic [1:0]  i_in_user,   // cmd[1:0]
    // master side of the block
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,  // read_data[31:0], irq_request[32],
                                     // next_source[39:33], next_valid[40], bad_access[41]
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_checked,
    output int          o_with_irq
);

    localparam int SRC_PER_BANK = BIC_SOURCES_PER_BANK;
    localparam int MAX_REPORTS  = 10;

    // same bit order as the low 42 bits of the result transaction
    typedef struct packed {
        logic                  bad;
        logic                  vld;
        logic [BIC_SRC_W-1:0]  src;
        logic                  irq;
        logic [31:0]           rdata;
    } t_irq_result;

    // predicted controller state
    logic [31:0] mask_q   [NUM_BANKS];
    logic [31:0] hw_q     [NUM_BANKS];
    logic [31:0] soft_q   [NUM_BANKS];
    logic [31:0] prev_q   [NUM_BANKS];
    logic [31:0] select_q [NUM_BANKS];
    logic [2:0]  trig_q   [NUM_BANKS][SRC_PER_BANK];

    t_irq_result expected_results [$];
    int          n_fail;
    int          n_checked;
    int          n_irq;

    // does a source latch pending for this level pair
    function automatic logic latch_hit(input logic [2:0] kind, input logic lvl,
                                       input logic prv);
        case (kind)
            BIC_TRIG_LEVEL_HIGH: return lvl;
            BIC_TRIG_LEVEL_LOW:  return ~lvl;
            BIC_TRIG_RISE:       return lvl & ~prv;
            BIC_TRIG_FALL:       return prv & ~lvl;
            BIC_TRIG_BOTH:       return lvl ^ prv;
            default:             return 1'b0;
        endcase
    endfunction

    // apply one transaction to the predicted state and build its result
    function automatic t_irq_result apply_txn(input logic [1:0] cmd, input logic [1:0] bank,
                                              input logic [5:0] off, input logic [31:0] wd,
                                              input logic [31:0] lv);
        t_irq_result res;
        logic        wr;
        logic        hi;
        logic        known;
        logic [5:0]  sset_off;
        logic [5:0]  sclr_off;
        logic [31:0] act;
        int          w;
        res   = '0;
        known = 1'b1;
        wr    = (cmd == BIC_CMD_WRITE);
        hi    = (bank >= BIC_HI_BANK_FIRST);
        sset_off = hi ? BIC_OFF_SSET_HI : BIC_OFF_SSET_LO;
        sclr_off = hi ? BIC_OFF_SCLR_HI : BIC_OFF_SCLR_LO;
        if (cmd == BIC_CMD_SAMPLE) begin
            // latch per trigger type, then remember the levels for edge detection
            if (bank < NUM_BANKS) begin
                for (int i = 0; i < SRC_PER_BANK; i++) begin
                    if (latch_hit(trig_q[bank][i], lv[i], prev_q[bank][i]))
                        hw_q[bank][i] = 1'b1;
                end
                prev_q[bank] = lv;
            end
        end else if (cmd == BIC_CMD_READ || cmd == BIC_CMD_WRITE) begin
            if (bank >= NUM_BANKS) begin
                res.bad = 1'b1;
            end else begin
                if (off[1:0] != 2'b00) begin
                    known = 1'b0;
                end else if (off == sset_off) begin
                    if (wr) soft_q[bank] = soft_q[bank] | wd;
                    else res.rdata = soft_q[bank];
                end else if (off == sclr_off) begin
                    if (wr) soft_q[bank] = soft_q[bank] & ~wd;
                end else begin
                    case (off)
                        BIC_OFF_MASK: begin
                            if (wr) mask_q[bank] = wd;
                            else res.rdata = mask_q[bank];
                        end
                        BIC_OFF_RAW: begin
                            if (!wr) res.rdata = hw_q[bank] | soft_q[bank];
                        end
                        BIC_OFF_CLR: begin
                            if (wr) hw_q[bank] = hw_q[bank] & ~wd;
                        end
                        BIC_OFF_MSTAT: begin
                            if (!wr) res.rdata = (hw_q[bank] | soft_q[bank]) & mask_q[bank];
                        end
                        BIC_OFF_TYPE0, BIC_OFF_TYPE1, BIC_OFF_TYPE2, BIC_OFF_TYPE3: begin
                            // eight sources per word, one nibble each, top bit unused
                            w = off[3:2];
                            for (int k = 0; k < 8; k++) begin
                                if (wr) trig_q[bank][w * 8 + k] = wd[4 * k +: 3];
                                else res.rdata[4 * k +: 3] = trig_q[bank][w * 8 + k];
                            end
                        end
                        // only low banks get here, the high banks take this offset as soft clear
                        BIC_OFF_SEL: begin
                            if (wr) select_q[bank] = wd;
                            else res.rdata = select_q[bank];
                        end
                        default: known = 1'b0;
                    endcase
                end
                if (!known) begin
                    res.bad   = 1'b1;
                    res.rdata = '0;
                end
                if (wr) res.rdata = '0;
            end
        end

        // lowest pending unmasked source over all banks, scanned top down
        for (int b = NUM_BANKS - 1; b >= 0; b--) begin
            act = (hw_q[b] | soft_q[b]) & mask_q[b];
            for (int i = SRC_PER_BANK - 1; i >= 0; i--) begin
                if (act[i]) begin
                    res.vld = 1'b1;
                    res.src = BIC_SRC_W'(b * SRC_PER_BANK + i);
                end
            end
        end
        res.irq = res.vld;
        return res;
    endfunction

    // compare results first, then queue the prediction for a new input transaction
    always @(posedge i_clk) begin
        t_irq_result got;
        t_irq_result want;
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                mask_q[b]   = '0;
                hw_q[b]     = '0;
                soft_q[b]   = '0;
                prev_q[b]   = '0;
                select_q[b] = '0;
                for (int i = 0; i < SRC_PER_BANK; i++)
                    trig_q[b][i] = BIC_TRIG_LEVEL_HIGH;
            end
            expected_results.delete();
            n_fail    = 0;
            n_checked = 0;
            n_irq     = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = t_irq_result'(i_out_data[41:0]);
                n_checked++;
                if (got.vld) n_irq++;
                if (expected_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: rd=%h irq=%b src=%0d vld=%b bad=%b",
                                 $realtime, got.rdata, got.irq, got.src, got.vld, got.bad);
                end else begin
                    want = expected_results.pop_front();
                    if (got.rdata !== want.rdata || got.irq !== want.irq ||
                            got.src !== want.src || got.vld !== want.vld ||
                            got.bad !== want.bad) begin
                        n_fail++;
                        if (n_fail <= MAX_REPORTS) begin
                            $display("%0t: result %0d mismatch", $realtime, n_checked);
                            $display("    expected rd=%h irq=%b src=%0d vld=%b bad=%b",
                                     want.rdata, want.irq, want.src, want.vld, want.bad);
                            $display("    actual   rd=%h irq=%b src=%0d vld=%b bad=%b",
                                     got.rdata, got.irq, got.src, got.vld, got.bad);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_txn(i_in_user, i_in_data[1:0], i_in_data[7:2],
                                                     i_in_data[39:8], i_in_data[71:40]));
        end
        o_fail_count  <= n_fail;
        o_outstanding <= expected_results.size();
        o_checked     <= n_checked;
        o_with_irq    <= n_irq;
    end

endmodule

[bench/tb_banked_interrupt_controller.sv]
// testbench top for the banked interrupt controller: clock, reset, stimulus and verdict
// depends on bic_pkg, banked_interrupt_controller and bic_result_checker
`timescale 1ns / 1ps

module tb_banked_interrupt_controller;
    import bic_pkg::*;

    localparam int          ITEMS_PER_PHASE = 490;
    localparam int          HOLD_CYCLES     = 64;
    localparam int          DRAIN_CYCLES    = 10;
    localparam int unsigned LIMIT_CYCLES    = 200_000;

    // codes that name nothing in the block
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam logic [1:0] BANK_ABSENT   = 2'd3;
    localparam logic [5:0] OFF_UNALIGNED = 6'h03;
    localparam logic [5:0] OFF_HOLE_20   = 6'h20;
    localparam logic [5:0] OFF_HOLE_38   = 6'h38;
    localparam logic [5:0] OFF_HOLE_3C   = 6'h3c;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;  // bank[1:0], reg_offset[7:2], write_data[39:8],
                                      // line_levels[71:40]
    logic [1:0]  s_axis_tuser  = '0;  // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // read_data[31:0], irq_request[32],
                                      // next_source[39:33], next_valid[40], bad_access[41]

    int fail_count;
    int outstanding;
    int checked;
    int with_irq;

    int tx_gap_pct = 0;
    int rx_gap_pct = 0;
    bit hold_req   = 1'b0;
    int n_sent     = 0;

    always #5 i_clk = ~i_clk;

    banked_interrupt_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bic_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_with_irq    (with_irq)
    );

    // offer one transaction after an optional random gap, return once it is taken
    task automatic send_txn(input logic [1:0] cmd, input logic [1:0] bank,
                            input logic [5:0] off, input logic [31:0] wd,
                            input logic [31:0] lv);
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lv, wd, off, bank};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_sent++;
    endtask

    // stop offering and wait for every predicted result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // any register that exists in the given bank
    function automatic logic [5:0] pick_reg_offset(input logic [1:0] bank);
        logic hi;
        hi = (bank >= BIC_HI_BANK_FIRST);
        case ($urandom_range(9))
            0: return BIC_OFF_MASK;
            1: return BIC_OFF_RAW;
            2: return BIC_OFF_CLR;
            3: return BIC_OFF_MSTAT;
            4: return BIC_OFF_TYPE0;
            5: return BIC_OFF_TYPE1;
            6: return BIC_OFF_TYPE2;
            7: return BIC_OFF_TYPE3;
            8: return hi ? BIC_OFF_SSET_HI : BIC_OFF_SSET_LO;
            default: begin
                if (hi) return BIC_OFF_SCLR_HI;
                return $urandom_range(1) ? BIC_OFF_SEL : BIC_OFF_SCLR_LO;
            end
        endcase
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_gap_pct);
        end
    end

    // run limit
    initial begin : watchdog
        int unsigned n_cycles;
        n_cycles = 0;
        while (n_cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("tb_banked_interrupt_controller: FAIL");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [1:0]  cmd;
        logic [1:0]  bank;
        logic [5:0]  off;
        logic [31:0] wd;
        logic [31:0] lv;
        int          pick;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values, then level-high latching while every source is masked
        send_txn(BIC_CMD_READ,   2'd0, BIC_OFF_MASK, $urandom, $urandom);
        send_txn(BIC_CMD_SAMPLE, 2'd0, BIC_OFF_MASK, $urandom, '1);
        send_txn(BIC_CMD_READ,   2'd0, BIC_OFF_RAW,  $urandom, $urandom);
        send_txn(BIC_CMD_WRITE,  2'd0, BIC_OFF_MASK, 32'h8000_0001, $urandom);

        // one source per trigger code, the never-triggering codes included
        send_txn(BIC_CMD_WRITE,  2'd1, BIC_OFF_TYPE0, 32'h7654_3210, $urandom);
        send_txn(BIC_CMD_WRITE,  2'd1, BIC_OFF_MASK,  '1, $urandom);
        send_txn(BIC_CMD_SAMPLE, 2'd1, BIC_OFF_MASK,  $urandom, '0);
        send_txn(BIC_CMD_SAMPLE, 2'd1, BIC_OFF_MASK,  $urandom, '1);
        send_txn(BIC_CMD_SAMPLE, 2'd1, BIC_OFF_MASK,  $urandom, '0);
        send_txn(BIC_CMD_READ,   2'd1, BIC_OFF_TYPE0, $urandom, $urandom);
        send_txn(BIC_CMD_READ,   2'd1, BIC_OFF_MSTAT, $urandom, $urandom);

        // status writes are dropped, clear reads back zero
        send_txn(BIC_CMD_WRITE, 2'd0, BIC_OFF_RAW,   '1, $urandom);
        send_txn(BIC_CMD_WRITE, 2'd0, BIC_OFF_MSTAT, '1, $urandom);
        send_txn(BIC_CMD_WRITE, 2'd0, BIC_OFF_CLR,   '1, $urandom);
        send_txn(BIC_CMD_READ,  2'd0, BIC_OFF_CLR,   $urandom, $urandom);

        // soft set/clear in both placements, select hidden behind soft clear in bank 2
        send_txn(BIC_CMD_WRITE, 2'd2, BIC_OFF_MASK,    '1, $urandom);
        send_txn(BIC_CMD_WRITE, 2'd2, BIC_OFF_SSET_HI, 32'h8000_0000, $urandom);
        send_txn(BIC_CMD_READ,  2'd2, BIC_OFF_SSET_HI, $urandom, $urandom);
        send_txn(BIC_CMD_READ,  2'd2, BIC_OFF_SCLR_HI, $urandom, $urandom);
        send_txn(BIC_CMD_WRITE, 2'd2, BIC_OFF_SCLR_HI, '1, $urandom);
        send_txn(BIC_CMD_WRITE, 2'd0, BIC_OFF_SEL,     32'ha5a5_a5a5, $urandom);
        send_txn(BIC_CMD_READ,  2'd0, BIC_OFF_SEL,     $urandom, $urandom);
        send_txn(BIC_CMD_WRITE, 2'd0, BIC_OFF_SSET_LO, 32'h0000_0001, $urandom);
        send_txn(BIC_CMD_READ,  2'd0, BIC_OFF_SCLR_LO, $urandom, $urandom);

        // offsets that name nothing, the absent bank and the spare command
        send_txn(BIC_CMD_READ,  2'd0, BIC_OFF_SSET_HI, $urandom, $urandom);
        send_txn(BIC_CMD_WRITE, 2'd2, BIC_OFF_SSET_LO, '1, $urandom);
        send_txn(BIC_CMD_READ,  2'd1, OFF_UNALIGNED,   $urandom, $urandom);
        send_txn(BIC_CMD_WRITE, 2'd1, OFF_HOLE_20,     '1, $urandom);
        send_txn(BIC_CMD_READ,  2'd1, OFF_HOLE_38,     $urandom, $urandom);
        send_txn(BIC_CMD_READ,  2'd1, OFF_HOLE_3C,     $urandom, $urandom);
        send_txn(BIC_CMD_WRITE, BANK_ABSENT, BIC_OFF_MASK, '1, $urandom);
        send_txn(BIC_CMD_SAMPLE, BANK_ABSENT, BIC_OFF_MASK, $urandom, '1);
        send_txn(CMD_UNUSED, 2'd0, BIC_OFF_MASK, '1, '1);
        wait_drained();

        // random traffic under three pacing schemes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_gap_pct = 38; rx_gap_pct = 81; end
                1: begin tx_gap_pct = 81; rx_gap_pct = 38; end
                default: begin tx_gap_pct = 0; rx_gap_pct = 0; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long result-side hold while the sender keeps offering
                if (phase == 2 && n == 100) hold_req = 1'b1;
                bank = 2'($urandom_range(2));
                wd   = $urandom;
                lv   = $urandom;
                pick = $urandom_range(99);
                if (pick < 40) begin
                    cmd = BIC_CMD_SAMPLE;
                    off = 6'($urandom);
                    case ($urandom_range(3))
                        0: lv = '0;
                        1: lv = '1;
                        default: ;
                    endcase
                end else if (pick < 62) begin
                    // writes lean toward clearing so pending bits keep turning over
                    cmd = BIC_CMD_WRITE;
                    off = ($urandom_range(2) == 0) ? BIC_OFF_CLR : pick_reg_offset(bank);
                    if ($urandom_range(3) == 0) wd = '1;
                end else if (pick < 85) begin
                    cmd = BIC_CMD_READ;
                    off = pick_reg_offset(bank);
                end else begin
                    cmd  = 2'($urandom);
                    bank = 2'($urandom);
                    off  = 6'($urandom);
                end
                send_txn(cmd, bank, off, wd, lv);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d transactions over directed, slow-sender, slow-receiver and full-rate",
                 n_sent);
        $display("phases; %0d results checked, %0d with a pending source", checked, with_irq);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_banked_interrupt_controller: PASS");
        end else begin
            $display("tb_banked_interrupt_controller: FAIL");
        end
        $finish;
    end

endmodule
